/* rtl/core/ipv6ehw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 extension header walker package
// Widths, next-header codes, fixed header offsets and the parser phase type.
// ----------------------------------------------------------------------------
package ipv6ehw_pkg;

  localparam int POS_W = 17;
  localparam int LEN_W = 16;

  localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_PLEN_HI    = 17'd4;
  localparam logic [POS_W-1:0] POS_PLEN_LO    = 17'd5;
  localparam logic [POS_W-1:0] POS_NEXT_HDR   = 17'd6;
  localparam logic [POS_W-1:0] POS_FIXED_LAST = 17'd39;
  localparam logic [POS_W-1:0] FIXED_HDR_LEN  = 17'd40;

  localparam logic [7:0] NH_HOPOPT   = 8'd0;
  localparam logic [7:0] NH_TCP      = 8'd6;
  localparam logic [7:0] NH_UDP      = 8'd17;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_ICMPV6   = 8'd58;
  localparam logic [7:0] NH_NONE     = 8'd59;
  localparam logic [7:0] NH_DSTOPT   = 8'd60;

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_EXT,
    PH_ROUTE,
    PH_FRAG,
    PH_TCP,
    PH_DONE
  } phase_t;

  // Registered input item handed from the input stage to the walker.
  typedef struct packed {
    logic       valid;
    logic [7:0] pkt_byte;
    logic       last_byte;
  } item_t;

endpackage : ipv6ehw_pkg
`default_nettype wire

/* rtl/core/ipv6ehw_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 extension header walker channels
// Byte stream channel and per-packet result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipv6ehw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;

  modport source (output valid, output pkt_byte, output last_byte, input ready);
  modport sink (input valid, input pkt_byte, input last_byte, output ready);
endinterface : ipv6ehw_byte_if

interface ipv6ehw_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  proto;
  logic [16:0] payload_offset;
  logic [15:0] payload_len;
  logic        has_frag;
  logic        later_fragment;
  logic        routing_error;
  logic [16:0] error_pointer;

  modport source (output valid, output found, output proto, output payload_offset,
                  output payload_len, output has_frag, output later_fragment,
                  output routing_error, output error_pointer, input ready);
  modport sink (input valid, input found, input proto, input payload_offset,
                input payload_len, input has_frag, input later_fragment,
                input routing_error, input error_pointer, output ready);
endinterface : ipv6ehw_res_if
`default_nettype wire

/* rtl/core/ipv6ehw_in_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 extension header walker input register
// Captures one byte item and holds it until the walker takes it.
// ----------------------------------------------------------------------------
module ipv6ehw_in_reg
  import ipv6ehw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  ipv6ehw_byte_if.sink  pkt,
  input  wire logic     take,
  output item_t         item
);

  logic       valid;
  logic [7:0] pkt_byte;
  logic       last_byte;

  // A new item may enter when the register is empty or being emptied.
  assign pkt.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pkt.ready) begin
      valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      pkt_byte  <= pkt.pkt_byte;
      last_byte <= pkt.last_byte;
    end
  end

  assign item.valid     = valid;
  assign item.pkt_byte  = pkt_byte;
  assign item.last_byte = last_byte;

endmodule : ipv6ehw_in_reg
`default_nettype wire

/* rtl/core/ipv6ehw_walker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 extension header walker core
// Per-packet header chain state, one byte per cycle unless a waiting result stalls it, and the result register.
// ----------------------------------------------------------------------------
module ipv6ehw_walker
  import ipv6ehw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire item_t     item,
  output logic           take,
  ipv6ehw_res_if.source  res
);

  localparam logic [POS_W-1:0] REL_NH       = 17'd0;
  localparam logic [POS_W-1:0] REL_LEN      = 17'd1;
  localparam logic [POS_W-1:0] REL_FOFF_HI  = 17'd2;
  localparam logic [POS_W-1:0] REL_FOFF_LO  = 17'd3;
  localparam logic [POS_W-1:0] REL_SEGS     = 17'd3;
  localparam logic [POS_W-1:0] REL_TCP_DOFF = 17'd12;
  localparam logic [POS_W-1:0] FRAG_HDR_LEN = 17'd8;
  localparam logic [5:0]       MIN_L4_LEN   = 6'd8;

  // Per-packet state.
  phase_t           phase,    phase_next;
  logic [POS_W-1:0] pos,      pos_next;
  logic [LEN_W-1:0] iplen,    iplen_next;
  logic [7:0]       first_nh, first_nh_next;
  logic [7:0]       cur_nh,   cur_nh_next;
  logic [POS_W-1:0] hstart,   hstart_next;
  logic [POS_W-1:0] hend,     hend_next;
  logic             fseen,    fseen_next;
  logic             fnz,      fnz_next;

  // Decision of the current byte.
  logic             fin;
  logic             fin_found;
  logic             fin_rerr;
  logic [POS_W-1:0] fin_off;
  logic [POS_W-1:0] fin_ptr;

  logic             do_walk;
  logic             do_chk;
  logic [5:0]       chk_need;
  logic [POS_W-1:0] lim;
  logic [POS_W-1:0] rel;
  logic             active;
  logic [11:0]      ext_bytes;
  logic [POS_W-1:0] hend_calc;
  logic             fnz_low;
  logic [7:0]       b;

  // Result register contents.
  logic             out_valid;
  logic             r_found;
  logic [7:0]       r_proto;
  logic [16:0]      r_off;
  logic [15:0]      r_len;
  logic             r_has_frag;
  logic             r_later;
  logic             r_rerr;
  logic [16:0]      r_ptr;

  logic             n_found;
  logic [7:0]       n_proto;
  logic [16:0]      n_off;
  logic [15:0]      n_len;
  logic [16:0]      n_ptr;

  assign take = item.valid && (!out_valid || res.ready);

  assign b         = item.pkt_byte;
  assign lim       = {1'b0, iplen} + FIXED_HDR_LEN;
  assign rel       = pos - hstart;
  assign active    = (pos >= hstart);
  assign ext_bytes = {1'b0, b, 3'b000} + 12'd8;
  assign hend_calc = hstart + {5'b00000, ext_bytes};
  assign fnz_low   = fnz || (b[7:3] != 5'd0);

  // Next state and decision for the byte in the input register.
  always_comb begin
    phase_next    = phase;
    pos_next      = (pos != POS_MAX) ? pos + 17'd1 : pos;
    iplen_next    = iplen;
    first_nh_next = first_nh;
    cur_nh_next   = cur_nh;
    hstart_next   = hstart;
    hend_next     = hend;
    fseen_next    = fseen;
    fnz_next      = fnz;
    fin           = 1'b0;
    fin_found     = 1'b0;
    fin_rerr      = 1'b0;
    fin_off       = hstart;
    fin_ptr       = hstart + 17'd3;
    do_walk       = 1'b0;
    do_chk        = 1'b0;
    chk_need      = MIN_L4_LEN;

    case (phase)
      PH_FIXED: begin
        if (pos == POS_PLEN_HI) begin
          iplen_next = {b, 8'h00};
        end else if (pos == POS_PLEN_LO) begin
          iplen_next = {iplen[15:8], b};
        end else if (pos == POS_NEXT_HDR) begin
          first_nh_next = b;
        end else if (pos == POS_FIXED_LAST) begin
          hstart_next = FIXED_HDR_LEN;
          cur_nh_next = first_nh;
          do_walk     = 1'b1;
        end
      end
      PH_EXT, PH_ROUTE: begin
        if (active) begin
          if (rel == REL_NH) begin
            cur_nh_next = b;
          end else if (rel == REL_LEN) begin
            hend_next = hend_calc;
            if (phase == PH_EXT) begin
              hstart_next = hend_calc;
              do_walk     = 1'b1;
            end
          end else if (rel == REL_SEGS) begin
            if (b != 8'd0) begin
              fin      = 1'b1;
              fin_rerr = 1'b1;
            end else begin
              hstart_next = hend;
              do_walk     = 1'b1;
            end
          end
        end
      end
      PH_FRAG: begin
        if (active) begin
          if (rel == REL_NH) begin
            cur_nh_next = b;
            fseen_next  = 1'b1;
            fnz_next    = 1'b0;
          end else if (rel == REL_FOFF_HI) begin
            fnz_next = (b != 8'd0);
          end else if (rel == REL_FOFF_LO) begin
            fnz_next    = fnz_low;
            hstart_next = hstart + FRAG_HDR_LEN;
            if (fnz_low) begin
              // A later fragment carries no upper header; report what follows.
              fin       = 1'b1;
              fin_found = 1'b1;
              fin_off   = hstart + FRAG_HDR_LEN;
            end else begin
              do_walk = 1'b1;
            end
          end
        end
      end
      PH_TCP: begin
        if (active && rel == REL_TCP_DOFF) begin
          do_chk   = 1'b1;
          chk_need = {b[7:4], 2'b00};
        end
      end
      default: begin
      end
    endcase

    if (do_walk) begin
      if (cur_nh_next == NH_NONE || hstart_next >= lim) begin
        fin = 1'b1;
      end else begin
        case (cur_nh_next)
          NH_HOPOPT, NH_DSTOPT: phase_next = PH_EXT;
          NH_ROUTING:           phase_next = PH_ROUTE;
          NH_FRAGMENT:          phase_next = PH_FRAG;
          NH_ICMPV6, NH_UDP:    do_chk     = 1'b1;
          NH_TCP: begin
            // Only a first fragment needs the TCP data offset to be seen.
            if (fseen_next && !fnz_next) begin
              phase_next = PH_TCP;
            end else begin
              fin       = 1'b1;
              fin_found = 1'b1;
              fin_off   = hstart_next;
            end
          end
          default: begin
            fin       = 1'b1;
            fin_found = 1'b1;
            fin_off   = hstart_next;
          end
        endcase
      end
    end

    if (do_chk) begin
      fin     = 1'b1;
      fin_off = hstart_next;
      fin_found = !(fseen_next && !fnz_next &&
                    ((lim - hstart_next) < {11'd0, chk_need}));
    end

    // A truncated packet ends the walk with nothing found.
    if (item.last_byte && phase != PH_DONE && !fin) begin
      fin       = 1'b1;
      fin_found = 1'b0;
      fin_rerr  = 1'b0;
    end

    if (fin) begin
      phase_next = PH_DONE;
    end

    if (phase == PH_DONE) begin
      // Bytes after the decision only advance the position.
      phase_next    = PH_DONE;
      iplen_next    = iplen;
      first_nh_next = first_nh;
      cur_nh_next   = cur_nh;
      hstart_next   = hstart;
      hend_next     = hend;
      fseen_next    = fseen;
      fnz_next      = fnz;
    end
  end

  // Result fields of the decision.
  always_comb begin
    n_found = fin_found;
    n_proto = fin_found ? cur_nh_next : first_nh_next;
    n_off   = fin_found ? fin_off : '0;
    n_len   = (fin_found && lim >= fin_off) ? 16'(lim - fin_off) : '0;
    n_ptr   = fin_rerr ? fin_ptr : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIXED;
      pos      <= '0;
      iplen    <= '0;
      first_nh <= '0;
      cur_nh   <= '0;
      hstart   <= FIXED_HDR_LEN;
      hend     <= '0;
      fseen    <= 1'b0;
      fnz      <= 1'b0;
    end else if (take) begin
      if (item.last_byte) begin
        // The last byte of a packet leaves a clean state for the next one.
        phase    <= PH_FIXED;
        pos      <= '0;
        iplen    <= '0;
        first_nh <= '0;
        cur_nh   <= '0;
        hstart   <= FIXED_HDR_LEN;
        hend     <= '0;
        fseen    <= 1'b0;
        fnz      <= 1'b0;
      end else begin
        phase    <= phase_next;
        pos      <= pos_next;
        iplen    <= iplen_next;
        first_nh <= first_nh_next;
        cur_nh   <= cur_nh_next;
        hstart   <= hstart_next;
        hend     <= hend_next;
        fseen    <= fseen_next;
        fnz      <= fnz_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && fin) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fin) begin
      r_found    <= n_found;
      r_proto    <= n_proto;
      r_off      <= n_off;
      r_len      <= n_len;
      r_has_frag <= fseen_next;
      r_later    <= fnz_next;
      r_rerr     <= fin_rerr;
      r_ptr      <= n_ptr;
    end
  end

  // The result register only loads fields computed before the end-of-packet clear.
  always_comb begin
    res.valid          = out_valid;
    res.found          = r_found;
    res.proto          = r_proto;
    res.payload_offset = r_off;
    res.payload_len    = r_len;
    res.has_frag       = r_has_frag;
    res.later_fragment = r_later;
    res.routing_error  = r_rerr;
    res.error_pointer  = r_ptr;
  end

`ifndef NO_ASSERTIONS
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_DONE) |-> !fin)
    else $error("decided packet produced a second result");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (take && item.last_byte) |=> (phase == PH_FIXED && pos == '0))
    else $error("packet state not cleared after last byte");

  a_hstart_floor: assert property (@(posedge clk) disable iff (rst)
    hstart >= FIXED_HDR_LEN)
    else $error("header start below the fixed header end");

  a_found_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && r_found) |-> (r_off >= FIXED_HDR_LEN && !r_rerr))
    else $error("found result with bad offset or routing error");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(r_off) && $stable(r_proto)))
    else $error("result changed while stalled");
`endif

endmodule : ipv6ehw_walker
`default_nettype wire

/* rtl/core/ipv6_extension_header_walker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 extension header walker
// Follows the next-header chain of a byte-serial IPv6 packet and reports the
// upper-layer protocol, payload offset and length, and fragment flags.
// ----------------------------------------------------------------------------
// Channel  Dir  Item                         Accepted when
// pkt      in   pkt_byte, last_byte          pkt.valid && pkt.ready
// res      out  one result per packet        res.valid && res.ready
//
// One byte is accepted every cycle while results are taken.
// The byte that decides a packet is walked while it sits in the input register;
// its result is registered when the walker takes it and offered from the next cycle.
// A waiting result stalls the walker; the input register still takes one item.
// rst is synchronous and clears the packet state and both valid flags.
// ----------------------------------------------------------------------------
module ipv6_extension_header_walker
  import ipv6ehw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  ipv6ehw_byte_if.sink  pkt,
  ipv6ehw_res_if.source res
);

  item_t item;
  logic  take;

  ipv6ehw_in_reg u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .pkt  (pkt),
    .take (take),
    .item (item)
  );

  ipv6ehw_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .res  (res)
  );

endmodule : ipv6_extension_header_walker
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker testbench
// Sends IPv6 packets one byte per item, starting with a short directed set and
// then random header chains. A predictor in this file follows the same
// next-header walk and queues the result that each packet should produce.
// Every result the block hands out is compared field by field with the oldest
// queued one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb
  import ipv6ehw_pkg::*;
();

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_BYTES    = 300;
  localparam int FRAG_HDR_LEN    = 8;
  localparam int MIN_L4_LEN      = 8;
  localparam int RT_SEG_LEFT     = 3;
  localparam int TCP_DOFF_BYTE   = 12;

  typedef struct {
    logic        found;
    logic [7:0]  proto;
    logic [16:0] payload_offset;
    logic [15:0] payload_len;
    logic        has_frag;
    logic        later_fragment;
    logic        routing_error;
    logic [16:0] error_pointer;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipv6ehw_byte_if byte_ch ();
  ipv6ehw_res_if  result_ch ();

  ipv6_extension_header_walker u_dut (
    .clk (clk),
    .rst (rst),
    .pkt (byte_ch),
    .res (result_ch)
  );

  always #5 clk = ~clk;

  // Walk state of the predictor.
  logic [16:0]  w_pos;
  logic [15:0]  w_plen;
  logic [7:0]   w_first_nh;
  logic [7:0]   w_cur_nh;
  logic [16:0]  w_hdr_start;
  logic [16:0]  w_hdr_end;
  logic         w_frag;
  logic         w_frag_late;
  logic         w_done;
  phase_t       w_phase;
  logic         w_have;
  walk_result_t w_res;

  walk_result_t pending_results[$];
  logic [7:0]   frame[$];

  logic idle_en = 1'b0;
  int   sink_hold = 0;
  int   cycles = 0;
  int   errors = 0;
  int   frames_sent = 0;
  int   bytes_sent = 0;
  int   results_seen = 0;
  int   found_seen = 0;
  int   rerr_seen = 0;
  int   frag_results = 0;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  task automatic walk_clear();
    w_pos       = '0;
    w_plen      = '0;
    w_first_nh  = '0;
    w_cur_nh    = '0;
    w_hdr_start = FIXED_HDR_LEN;
    w_hdr_end   = '0;
    w_frag      = 1'b0;
    w_frag_late = 1'b0;
    w_done      = 1'b0;
    w_phase     = PH_FIXED;
  endtask

  task automatic walk_finish(input logic fnd, input logic [16:0] off,
                             input logic rerr, input logic [16:0] ptr);
    logic [17:0] lim;
    logic [17:0] diff;
    lim  = {2'b00, w_plen} + {1'b0, FIXED_HDR_LEN};
    diff = lim - {1'b0, off};
    w_done  = 1'b1;
    w_phase = PH_DONE;
    w_res.found          = fnd;
    w_res.proto          = fnd ? w_cur_nh : w_first_nh;
    w_res.payload_offset = fnd ? off : '0;
    // Payload length saturates at zero when the payload starts past the end.
    w_res.payload_len    = (fnd && lim >= {1'b0, off}) ? diff[15:0] : '0;
    w_res.has_frag       = w_frag;
    w_res.later_fragment = w_frag_late;
    w_res.routing_error  = rerr;
    w_res.error_pointer  = rerr ? ptr : '0;
    w_have = 1'b1;
  endtask

  // Upper-layer header after a first fragment must fit before the payload end.
  task automatic size_check(input logic [17:0] need);
    logic [17:0] lim;
    lim = {2'b00, w_plen} + {1'b0, FIXED_HDR_LEN};
    if (w_frag && !w_frag_late && (lim - {1'b0, w_hdr_start}) < need)
      walk_finish(1'b0, '0, 1'b0, '0);
    else
      walk_finish(1'b1, w_hdr_start, 1'b0, '0);
  endtask

  task automatic walk_next();
    logic [17:0] lim;
    lim = {2'b00, w_plen} + {1'b0, FIXED_HDR_LEN};
    if (w_cur_nh == NH_NONE || {1'b0, w_hdr_start} >= lim) begin
      walk_finish(1'b0, '0, 1'b0, '0);
    end else begin
      case (w_cur_nh)
        NH_HOPOPT, NH_DSTOPT: w_phase = PH_EXT;
        NH_ROUTING:           w_phase = PH_ROUTE;
        NH_FRAGMENT:          w_phase = PH_FRAG;
        NH_ICMPV6, NH_UDP:    size_check(18'(MIN_L4_LEN));
        NH_TCP: begin
          if (w_frag && !w_frag_late) w_phase = PH_TCP;
          else walk_finish(1'b1, w_hdr_start, 1'b0, '0);
        end
        default: walk_finish(1'b1, w_hdr_start, 1'b0, '0);
      endcase
    end
  endtask

  task automatic walk_byte_in(input logic [7:0] b);
    logic [16:0] rel;
    if (w_phase == PH_FIXED) begin
      if (w_pos == POS_PLEN_HI) w_plen = {b, 8'h00};
      else if (w_pos == POS_PLEN_LO) w_plen[7:0] = b;
      else if (w_pos == POS_NEXT_HDR) w_first_nh = b;
      else if (w_pos == POS_FIXED_LAST) begin
        w_hdr_start = FIXED_HDR_LEN;
        w_cur_nh    = w_first_nh;
        walk_next();
      end
    end else if (w_phase != PH_DONE && w_pos >= w_hdr_start) begin
      rel = w_pos - w_hdr_start;
      case (w_phase)
        PH_EXT, PH_ROUTE: begin
          if (rel == 0) begin
            w_cur_nh = b;
          end else if (rel == 1) begin
            w_hdr_end = w_hdr_start + (({9'd0, b} + 17'd1) << 3);
            if (w_phase == PH_EXT) begin
              w_hdr_start = w_hdr_end;
              walk_next();
            end
          end else if (rel == RT_SEG_LEFT) begin
            if (b != 8'd0) begin
              walk_finish(1'b0, '0, 1'b1, w_hdr_start + 17'(RT_SEG_LEFT));
            end else begin
              w_hdr_start = w_hdr_end;
              walk_next();
            end
          end
        end
        PH_FRAG: begin
          if (rel == 0) begin
            w_cur_nh    = b;
            w_frag      = 1'b1;
            w_frag_late = 1'b0;
          end else if (rel == 2) begin
            w_frag_late = (b != 8'd0);
          end else if (rel == 3) begin
            if (b[7:3] != 5'd0) w_frag_late = 1'b1;
            w_hdr_start = w_hdr_start + 17'(FRAG_HDR_LEN);
            if (w_frag_late) walk_finish(1'b1, w_hdr_start, 1'b0, '0);
            else walk_next();
          end
        end
        PH_TCP: begin
          if (rel == TCP_DOFF_BYTE) size_check({12'd0, b[7:4], 2'b00});
        end
        default: ;
      endcase
    end
  endtask

  task automatic walk_step(input logic [7:0] b, input logic last);
    w_have = 1'b0;
    if (!w_done) walk_byte_in(b);
    if (w_pos != POS_MAX) w_pos = w_pos + 17'd1;
    if (last && !w_done) walk_finish(1'b0, '0, 1'b0, '0);
    if (w_have) pending_results.push_back(w_res);
    if (last) walk_clear();
  endtask

  // ------------------------------------------------------------------------
  // Channel drivers and result checker
  // ------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.pkt_byte  <= b;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    walk_step(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int keep);
    int n;
    n = (keep > 0 && keep < frame.size()) ? keep : frame.size();
    for (int i = 0; i < n; i++) send_byte(frame[i], i == n - 1);
    frame.delete();
    frames_sent++;
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold != 0) begin
        result_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        result_ch.ready <= 1'b1;
        sink_hold = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (result_ch.found) found_seen++;
      if (result_ch.routing_error) rerr_seen++;
      if (result_ch.has_frag) frag_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, found %0d proto %0d offset %0d",
                 $time, result_ch.found, result_ch.proto, result_ch.payload_offset);
      end else begin
        want = pending_results.pop_front();
        check_field("found", want.found, result_ch.found);
        check_field("proto", want.proto, result_ch.proto);
        check_field("payload_offset", want.payload_offset, result_ch.payload_offset);
        check_field("payload_len", want.payload_len, result_ch.payload_len);
        check_field("has_frag", want.has_frag, result_ch.has_frag);
        check_field("later_fragment", want.later_fragment, result_ch.later_fragment);
        check_field("routing_error", want.routing_error, result_ch.routing_error);
        check_field("error_pointer", want.error_pointer, result_ch.error_pointer);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Frame builders
  // ------------------------------------------------------------------------
  task automatic start_frame(input logic [7:0] nh);
    repeat (40) frame.push_back(8'($urandom_range(0, 255)));
    frame[POS_NEXT_HDR] = nh;
  endtask

  task automatic set_plen(input logic [15:0] plen);
    frame[POS_PLEN_HI] = plen[15:8];
    frame[POS_PLEN_LO] = plen[7:0];
  endtask

  task automatic add_junk(input int n);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_opts(input logic [7:0] nh, input logic [7:0] units);
    frame.push_back(nh);
    frame.push_back(units);
    add_junk((units + 1) * 8 - 2);
  endtask

  task automatic add_route(input logic [7:0] nh, input logic [7:0] units,
                           input logic [7:0] seg_left);
    frame.push_back(nh);
    frame.push_back(units);
    add_junk(1);
    frame.push_back(seg_left);
    add_junk((units + 1) * 8 - 4);
  endtask

  task automatic add_frag(input logic [7:0] nh, input logic [12:0] off,
                          input logic [1:0] rsvd, input logic more);
    frame.push_back(nh);
    add_junk(1);
    frame.push_back(off[12:5]);
    frame.push_back({off[4:0], rsvd, more});
    add_junk(4);
  endtask

  task automatic add_l4(input logic [7:0] proto, input int n, input logic [3:0] doff);
    int base;
    base = frame.size();
    add_junk(n);
    if (proto == NH_TCP && n > TCP_DOFF_BYTE)
      frame[base + TCP_DOFF_BYTE] = {doff, 4'($urandom_range(0, 15))};
  endtask

  function automatic logic [7:0] small_units();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(3, 8));
    return 8'($urandom_range(0, 2));
  endfunction

  task automatic build_random_frame(output int keep);
    logic [7:0]  chain[$];
    logic [12:0] off;
    int          n_ext;
    int          r;
    int          body;
    int          plen;
    n_ext = $urandom_range(0, 4);
    for (int i = 0; i < n_ext; i++) begin
      r = $urandom_range(0, 9);
      chain.push_back(r < 3 ? NH_HOPOPT : r < 5 ? NH_DSTOPT : r < 7 ? NH_ROUTING : NH_FRAGMENT);
    end
    r = $urandom_range(0, 19);
    chain.push_back(r < 6 ? NH_TCP : r < 10 ? NH_UDP : r < 13 ? NH_ICMPV6 :
                    r < 15 ? NH_NONE : 8'($urandom_range(0, 255)));
    start_frame(chain[0]);
    for (int i = 0; i < n_ext; i++) begin
      case (chain[i])
        NH_HOPOPT, NH_DSTOPT: add_opts(chain[i+1], small_units());
        NH_ROUTING: add_route(chain[i+1], small_units(),
                              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
        default: begin
          r = $urandom_range(0, 9);
          off = (r < 5) ? 13'd0 : (r < 8) ? 13'($urandom_range(1, 8191)) :
                13'd1 << $urandom_range(0, 12);
          add_frag(chain[i+1], off, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
      endcase
    end
    if (chain[n_ext] == NH_TCP)
      add_l4(NH_TCP, $urandom_range(0, 40), ($urandom_range(0, 3) == 0) ?
             4'($urandom_range(0, 15)) : 4'($urandom_range(5, 10)));
    else
      add_l4(chain[n_ext], $urandom_range(0, 16), 4'd0);
    body = frame.size() - 40;
    r = $urandom_range(0, 19);
    if (r < 14) plen = body;
    else if (r < 16) plen = body - $urandom_range(0, body < 16 ? body : 16);
    else if (r < 18) plen = body + $urandom_range(1, 16);
    else if (r < 19) plen = $urandom_range(0, 80);
    else plen = $urandom_range(0, 65535);
    set_plen(plen[15:0]);
    r = $urandom_range(0, 9);
    keep = (r == 0) ? $urandom_range(1, frame.size()) : 0;
    if (r == 1) add_junk($urandom_range(1, 8));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_transport();
    // TCP without fragments is found at once; the trailing bytes are ignored.
    start_frame(NH_TCP);
    add_l4(NH_TCP, 20, 4'd5);
    set_plen(16'd20);
    add_junk(5);
    send_frame(0);
    start_frame(NH_UDP);
    add_l4(NH_UDP, 8, 4'd0);
    set_plen(16'd8);
    send_frame(0);
    start_frame(NH_ICMPV6);
    add_l4(NH_ICMPV6, 8, 4'd0);
    set_plen(16'd8);
    send_frame(0);
    start_frame(8'd200);
    add_junk(4);
    set_plen(16'd4);
    send_frame(0);
    start_frame(NH_NONE);
    add_junk(10);
    set_plen(16'd10);
    send_frame(0);
  endtask

  task automatic test_ext_chain();
    start_frame(NH_HOPOPT);
    add_opts(NH_DSTOPT, 8'd0);
    add_opts(NH_UDP, 8'd2);
    add_l4(NH_UDP, 8, 4'd0);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
    // Zero payload length: the first extension header already lies past the end.
    start_frame(NH_HOPOPT);
    set_plen(16'd0);
    add_junk(8);
    send_frame(0);
    // The chain runs exactly to the payload end without reaching a transport.
    start_frame(NH_DSTOPT);
    add_opts(NH_TCP, 8'd1);
    set_plen(16'd16);
    send_frame(0);
  endtask

  task automatic test_routing();
    start_frame(NH_ROUTING);
    add_route(NH_TCP, 8'd1, 8'd0);
    add_l4(NH_TCP, 20, 4'd5);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
    start_frame(NH_ROUTING);
    add_route(NH_UDP, 8'd2, 8'd255);
    add_l4(NH_UDP, 8, 4'd0);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
  endtask

  task automatic test_fragments();
    // First fragment with a TCP header that just fits.
    start_frame(NH_FRAGMENT);
    add_frag(NH_TCP, 13'd0, 2'd0, 1'b1);
    add_l4(NH_TCP, 24, 4'd6);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
    // First fragment with a TCP data offset larger than what is left.
    start_frame(NH_FRAGMENT);
    add_frag(NH_TCP, 13'd0, 2'd0, 1'b1);
    add_l4(NH_TCP, 20, 4'd15);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
    start_frame(NH_FRAGMENT);
    add_frag(NH_UDP, 13'd0, 2'd0, 1'b1);
    add_l4(NH_UDP, 4, 4'd0);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
    start_frame(NH_FRAGMENT);
    add_frag(NH_UDP, 13'h0100, 2'd0, 1'b0);
    add_l4(NH_UDP, 8, 4'd0);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
    // Later fragment whose payload would start past the payload end.
    start_frame(NH_FRAGMENT);
    add_frag(NH_UDP, 13'h1234, 2'd0, 1'b0);
    add_l4(NH_UDP, 8, 4'd0);
    set_plen(16'd4);
    send_frame(0);
    // Reserved and more-fragments bits alone do not make a later fragment.
    start_frame(NH_FRAGMENT);
    add_frag(NH_ICMPV6, 13'd0, 2'd3, 1'b1);
    add_l4(NH_ICMPV6, 8, 4'd0);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
    // A second fragment header overwrites the flags of the first.
    start_frame(NH_FRAGMENT);
    add_frag(NH_FRAGMENT, 13'd0, 2'd0, 1'b1);
    add_frag(NH_UDP, 13'd1, 2'd0, 1'b0);
    add_l4(NH_UDP, 8, 4'd0);
    set_plen(16'(frame.size() - 40));
    send_frame(0);
  endtask

  task automatic test_truncation();
    add_junk(1);
    send_frame(0);
    start_frame(NH_UDP);
    add_l4(NH_UDP, 8, 4'd0);
    set_plen(16'd8);
    send_frame(21);
    start_frame(NH_FRAGMENT);
    add_frag(NH_TCP, 13'd0, 2'd0, 1'b1);
    add_l4(NH_TCP, 20, 4'd5);
    set_plen(16'(frame.size() - 40));
    send_frame(44);
    // Cut while the TCP decision still waits for the data offset byte.
    start_frame(NH_FRAGMENT);
    add_frag(NH_TCP, 13'd0, 2'd0, 1'b1);
    add_l4(NH_TCP, 20, 4'd5);
    set_plen(16'(frame.size() - 40));
    send_frame(55);
  endtask

  task automatic test_extremes();
    repeat (60) frame.push_back(8'hFF);
    send_frame(0);
    repeat (48) frame.push_back(8'h00);
    send_frame(0);
  endtask

  task automatic test_random_frames();
    int start_bytes;
    int keep;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      idle_en = ($urandom_range(0, 4) != 0);
      build_random_frame(keep);
      send_frame(keep);
    end
  endtask

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.pkt_byte  = 8'd0;
    byte_ch.last_byte = 1'b0;
    walk_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_en = 1'b1;
    test_transport();
    test_ext_chain();
    test_routing();
    idle_en = 1'b0;
    test_fragments();
    idle_en = 1'b1;
    test_truncation();
    test_extremes();
    test_random_frames();
    byte_ch.valid <= 1'b0;

    idle_en = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packets in %0d bytes; checked %0d results", frames_sent, bytes_sent,
             results_seen);
    $display("Results with payload found %0d, routing errors %0d, fragment header seen %0d",
             found_seen, rerr_seen, frag_results);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : tb
